// File: rtl/wave_table_sound_channel_macros.svh
// Assertion macros for the wave-table sound channel.
// Included by the top level; no other dependencies.
`ifndef WAVE_TABLE_SOUND_CHANNEL_MACROS_SVH
`define WAVE_TABLE_SOUND_CHANNEL_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define WTSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");
// Next-cycle implication, disabled while reset is asserted.
`define WTSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");
`else
`define WTSC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define WTSC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/wtsc_pkg.sv
// Types and constants for the wave-table sound channel.
// No dependencies.
`default_nettype none

package wtsc_pkg;

    typedef enum logic [2:0] {
        OP_WRITE_RAM   = 3'd0,
        OP_READ_RAM    = 3'd1,
        OP_TRIGGER     = 3'd2,
        OP_TIMER_TICK  = 3'd3,
        OP_LENGTH_TICK = 3'd4
    } wtsc_op_t;

    typedef enum logic [2:0] {
        REG_BANK_SELECT    = 3'd0,
        REG_TWO_BANK_MODE  = 3'd1,
        REG_PLAYBACK_EN    = 3'd2,
        REG_VOLUME_CODE    = 3'd3,
        REG_FORCE_3Q       = 3'd4,
        REG_LENGTH_EN      = 3'd5,
        REG_LENGTH_LOAD    = 3'd6,
        REG_FREQUENCY      = 3'd7
    } wtsc_reg_t;

    localparam int unsigned WAVE_BYTES  = 32;
    localparam int unsigned PERIOD_BASE = 2048;
    localparam int unsigned LENGTH_BASE = 256;

    typedef struct packed {
        logic [2:0] operation;
        logic [3:0] ram_address;
        logic [7:0] ram_data;
    } wtsc_in_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [3:0] sample_level;
        logic       channel_active;
        logic       sample_updated;
    } wtsc_out_t;

endpackage

`default_nettype wire

// File: rtl/wave_table_sound_channel.sv
// Wave-table sound channel: wave RAM, request stage, channel state and result register.
// Depends on wtsc_pkg and wave_table_sound_channel_macros.svh.
//
// Usage
//   Requests enter on s_valid/s_ready/s_item (write RAM, read RAM, trigger, timer tick,
//   length tick). Each request yields exactly one result on m_valid/m_ready/m_result:
//   read data, the current level, the playing flag and a fetch flag.
//   Settings are written through the APB port (register i at byte 4*i); pready is
//   always high and prdata returns the register value.
//   On the way to m_valid the wave RAM is written and read when a request is accepted,
//   and the request stage then updates the channel state and loads the result
//   register. Throughput is one request per cycle while the receiver does not stall.
//   When the receiver stalls the result register holds; one more request may sit in
//   the request stage, after which s_ready drops until the result is taken.
//   A synchronous active-low reset clears all settings and channel state; the wave RAM
//   is not cleared and reads of bytes never written return arbitrary data.
`default_nettype none

`include "wave_table_sound_channel_macros.svh"

module wave_table_sound_channel
    import wtsc_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // request channel
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire wtsc_in_t         s_item,
    // result channel
    output logic                  m_valid,
    input  wire logic             m_ready,
    output wtsc_out_t             m_result,
    // configuration
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [4:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int unsigned ADDR_W     = $clog2(WAVE_BYTES);
    localparam int unsigned BANK_BYTES = WAVE_BYTES / 2;

    // settings
    logic        bank_select_reg;
    logic        two_bank_mode_reg;
    logic        playback_enable_reg;
    logic [1:0]  volume_code_reg;
    logic        force_3q_reg;
    logic        length_enable_reg;
    logic [7:0]  length_load_reg;
    logic [10:0] frequency_reg;

    // channel state
    logic [5:0]  nibble_index_reg, nibble_index_next;
    logic [11:0] period_count_reg, period_count_next;
    logic [8:0]  length_count_reg, length_count_next;
    logic        playing_reg, playing_next;
    logic [3:0]  level_reg, level_next;

    // request stage
    logic        s1_valid_reg;
    wtsc_in_t    s1_item_reg;
    logic [7:0]  cpu_rd_reg;
    logic [7:0]  fetch_rd_reg;
    logic        s1_advance;
    logic        s_accept;

    // result register
    logic        out_valid_reg;
    wtsc_out_t   out_reg;
    wtsc_out_t   out_next;
    logic        sample_updated;

    logic [7:0]  wave_mem [WAVE_BYTES];

    logic [ADDR_W-1:0] cpu_addr;
    logic [ADDR_W-1:0] fetch_addr;
    logic [ADDR_W-1:0] bank_base;

    logic [2:0]  cfg_index;
    logic        cfg_write;
    logic [11:0] period_len;
    logic [3:0]  raw_nibble;
    logic [3:0]  scaled_nibble;

    assign pready    = 1'b1;
    assign cfg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_select_reg     <= 1'b0;
            two_bank_mode_reg   <= 1'b0;
            playback_enable_reg <= 1'b0;
            volume_code_reg     <= 2'd0;
            force_3q_reg        <= 1'b0;
            length_enable_reg   <= 1'b0;
            length_load_reg     <= 8'd0;
            frequency_reg       <= 11'd0;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_BANK_SELECT:   bank_select_reg     <= pwdata[0];
                REG_TWO_BANK_MODE: two_bank_mode_reg   <= pwdata[0];
                REG_PLAYBACK_EN:   playback_enable_reg <= pwdata[0];
                REG_VOLUME_CODE:   volume_code_reg     <= pwdata[1:0];
                REG_FORCE_3Q:      force_3q_reg        <= pwdata[0];
                REG_LENGTH_EN:     length_enable_reg   <= pwdata[0];
                REG_LENGTH_LOAD:   length_load_reg     <= pwdata[7:0];
                REG_FREQUENCY:     frequency_reg       <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_BANK_SELECT:   prdata = {31'd0, bank_select_reg};
            REG_TWO_BANK_MODE: prdata = {31'd0, two_bank_mode_reg};
            REG_PLAYBACK_EN:   prdata = {31'd0, playback_enable_reg};
            REG_VOLUME_CODE:   prdata = {30'd0, volume_code_reg};
            REG_FORCE_3Q:      prdata = {31'd0, force_3q_reg};
            REG_LENGTH_EN:     prdata = {31'd0, length_enable_reg};
            REG_LENGTH_LOAD:   prdata = {24'd0, length_load_reg};
            REG_FREQUENCY:     prdata = {21'd0, frequency_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // Handshake: the request stage moves on when the result register is free or being taken.
    assign s1_advance = s1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign s_accept   = s_valid && s_ready;
    assign m_valid    = out_valid_reg;
    assign m_result   = out_reg;

    // CPU side uses the bank that is not playing; playback reads the index the
    // request will see, i.e. after the request ahead of it has updated the state.
    assign bank_base  = bank_select_reg ? ADDR_W'(BANK_BYTES) : '0;
    assign cpu_addr   = ADDR_W'(s_item.ram_address) + (bank_select_reg ? '0
                                                       : ADDR_W'(BANK_BYTES));
    assign fetch_addr = bank_base + ADDR_W'(nibble_index_next[5:1]);

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            if (s_item.operation == OP_WRITE_RAM) begin
                wave_mem[cpu_addr] <= s_item.ram_data;
            end
            cpu_rd_reg   <= wave_mem[cpu_addr];
            fetch_rd_reg <= wave_mem[fetch_addr];
            s1_item_reg  <= s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    assign period_len = 12'(PERIOD_BASE) - {1'b0, frequency_reg};
    assign raw_nibble = nibble_index_reg[0] ? fetch_rd_reg[3:0] : fetch_rd_reg[7:4];

    always_comb begin
        if (force_3q_reg) begin
            scaled_nibble = raw_nibble - (raw_nibble >> 2);
        end else begin
            case (volume_code_reg)
                2'd0:    scaled_nibble = 4'd0;
                2'd1:    scaled_nibble = raw_nibble;
                2'd2:    scaled_nibble = raw_nibble >> 1;
                default: scaled_nibble = raw_nibble >> 2;
            endcase
        end
    end

    always_comb begin
        nibble_index_next = nibble_index_reg;
        period_count_next = period_count_reg;
        length_count_next = length_count_reg;
        playing_next      = playing_reg;
        level_next        = level_reg;
        sample_updated    = 1'b0;
        if (s1_advance) begin
            case (s1_item_reg.operation)
                OP_TRIGGER: begin
                    if (playback_enable_reg) begin
                        playing_next      = 1'b1;
                        nibble_index_next = 6'd0;
                        period_count_next = period_len;
                        length_count_next = 9'(LENGTH_BASE) - {1'b0, length_load_reg};
                    end
                end
                OP_TIMER_TICK: begin
                    if (playing_reg) begin
                        if (period_count_reg <= 12'd1) begin
                            period_count_next = period_len;
                            level_next        = scaled_nibble;
                            sample_updated    = 1'b1;
                            // wrap at 64 nibbles in two-bank mode, else at 32
                            nibble_index_next = two_bank_mode_reg
                                ? nibble_index_reg + 6'd1
                                : {1'b0, nibble_index_reg[4:0] + 5'd1};
                        end else begin
                            period_count_next = period_count_reg - 12'd1;
                        end
                    end
                end
                OP_LENGTH_TICK: begin
                    if (playing_reg && length_enable_reg) begin
                        if (length_count_reg <= 9'd1) begin
                            length_count_next = 9'd0;
                            playing_next      = 1'b0;
                        end else begin
                            length_count_next = length_count_reg - 9'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nibble_index_reg <= 6'd0;
            period_count_reg <= 12'd0;
            length_count_reg <= 9'd0;
            playing_reg      <= 1'b0;
            level_reg        <= 4'd0;
        end else begin
            nibble_index_reg <= nibble_index_next;
            period_count_reg <= period_count_next;
            length_count_reg <= length_count_next;
            level_reg        <= level_next;
            // clearing playback enable stops the channel at once
            if (cfg_write && cfg_index == REG_PLAYBACK_EN && !pwdata[0]) begin
                playing_reg <= 1'b0;
            end else begin
                playing_reg <= playing_next;
            end
        end
    end

    always_comb begin
        out_next.read_data      = (s1_item_reg.operation == OP_READ_RAM) ? cpu_rd_reg : 8'd0;
        out_next.sample_level   = level_next;
        out_next.channel_active = playing_next;
        out_next.sample_updated = sample_updated;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s1_advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            out_reg <= out_next;
        end
    end

    `WTSC_ASSERT_NEXT(a_update_only_on_tick, aclk, aresetn,
        s1_advance && s1_item_reg.operation != OP_TIMER_TICK, !m_result.sample_updated)
    `WTSC_ASSERT_NOW(a_off_when_disabled, aclk, aresetn, !playback_enable_reg, !playing_reg)
    `WTSC_ASSERT_NOW(a_period_nonzero, aclk, aresetn, playing_reg, period_count_reg != 12'd0)
    `WTSC_ASSERT_NOW(a_length_nonzero, aclk, aresetn, playing_reg, length_count_reg != 9'd0)

endmodule

`default_nettype wire
